// ===== rtl/core/agu_pkg.sv =====
// shared types, register indexes and constants for the gradient update block
package agu_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int SUM_WIDTH   = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic MODE_ADAGRAD  = 1'b0;
  localparam logic MODE_ADADELTA = 1'b1;

  localparam logic [VALUE_WIDTH-1:0] UMAX = {VALUE_WIDTH{1'b1}};
  localparam logic [VALUE_WIDTH-1:0] SMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] SMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 3'd0,
    CFG_LEARN_RATE = 3'd1,
    CFG_REG_ALPHA  = 3'd2,
    CFG_DECAY_RHO  = 3'd3,
    CFG_EPSILON    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                   mode;
    logic [15:0]            learn_rate;
    logic [15:0]            reg_alpha;
    logic [15:0]            decay_rho;
    logic [VALUE_WIDTH-1:0] epsilon;
  } cfg_t;

  typedef struct packed {
    logic [15:0]                   feature_index;
    logic [7:0]                    component_index;
    logic signed [VALUE_WIDTH-1:0] param_value;
    logic [VALUE_WIDTH-1:0]        grad_accum;
    logic [VALUE_WIDTH-1:0]        momentum_accum;
    logic                          last;
  } item_t;

  // queue entry: item, its update mode and weighted gradient
  typedef struct packed {
    item_t                         item;
    logic                          mode;
    logic signed [VALUE_WIDTH-1:0] wg;
  } qent_t;

  typedef struct packed {
    logic [15:0]                   index_out;
    logic [7:0]                    component_out;
    logic signed [VALUE_WIDTH-1:0] new_param;
    logic [VALUE_WIDTH-1:0]        new_grad_accum;
    logic [VALUE_WIDTH-1:0]        new_momentum;
    logic [VALUE_WIDTH-1:0]        local_rate;
    logic                          last_out;
  } res_t;

  typedef enum logic {
    RD_SQRT = 1'b0,
    RD_DIV  = 1'b1
  } rd_op_t;

  typedef struct packed {
    logic        start;
    rd_op_t      op;
    logic [63:0] a;
    logic [31:0] b;
  } rd_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } rd_rsp_t;

  typedef enum logic [4:0] {
    B_IDLE, B_SQ, B_SQW, B_NA1, B_NA2, B_GX, B_ROOTG, B_ROOTM, B_ROOTA,
    B_DIV, B_UPD, B_UPDW, B_MOM1, B_MOM2, B_MOM3, B_MOM4, B_PAR, B_FAC,
    B_MH, B_ML, B_RES, B_OUT
  } back_state_t;

endpackage

// ===== rtl/core/adaptive_gradient_update.sv =====
// AdaGrad / AdaDelta element update: front end, queue, back end, output register.
// In AdaGrad mode the back end does one root and one divide per item, in AdaDelta
// mode two roots and one divide, all in the shared one-bit-per-cycle root/divide
// unit; the back end takes a new item only after it has handed the last one out.
// The front end and queue take up to three items ahead of the back end.
// Synchronous active-low reset clears handshakes, sequencer and rate sum; registers reload defaults.
module adaptive_gradient_update (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_feature_index,
  input  logic [7:0]         in_component_index,
  input  logic signed [31:0] in_sparse_wt,
  input  logic signed [31:0] in_grad_in,
  input  logic signed [31:0] in_param_value,
  input  logic [31:0]        in_grad_accum,
  input  logic [31:0]        in_momentum_accum,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_index_out,
  output logic [7:0]         out_component_out,
  output logic signed [31:0] out_new_param,
  output logic [31:0]        out_new_grad_accum,
  output logic [31:0]        out_new_momentum,
  output logic [31:0]        out_local_rate,
  output logic [47:0]        out_rate_sum,
  output logic               out_last_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import agu_pkg::*;

  cfg_t                 cfg_r, cfg_nxt;
  item_t                in_item;
  logic                 push, q_full, q_valid, q_pop;
  qent_t                push_ent, q_head;
  logic                 back_valid, res_ready, load;
  res_t                 back_res;
  res_t                 res_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [SUM_WIDTH-1:0] rate_total_r, rate_total_nxt, sum_r, sum_sat;
  logic [SUM_WIDTH:0]   sum_raw;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:       cfg_nxt.mode       = cfg_wdata[0];
        CFG_LEARN_RATE: cfg_nxt.learn_rate = cfg_wdata[15:0];
        CFG_REG_ALPHA:  cfg_nxt.reg_alpha  = cfg_wdata[15:0];
        CFG_DECAY_RHO:  cfg_nxt.decay_rho  = cfg_wdata[15:0];
        CFG_EPSILON:    cfg_nxt.epsilon    = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= MODE_ADAGRAD;
      cfg_r.learn_rate <= 16'd3277;
      cfg_r.reg_alpha  <= 16'd0;
      cfg_r.decay_rho  <= 16'd62259;
      cfg_r.epsilon    <= 32'd4295;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_item.feature_index   = in_feature_index;
  assign in_item.component_index = in_component_index;
  assign in_item.param_value     = in_param_value;
  assign in_item.grad_accum      = in_grad_accum;
  assign in_item.momentum_accum  = in_momentum_accum;
  assign in_item.last            = in_last;

  agu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .sparse_wt      (in_sparse_wt),
    .grad_in        (in_grad_in),
    .mode           (cfg_r.mode),
    .q_full         (q_full),
    .push           (push),
    .push_ent       (push_ent)
  );

  agu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  agu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (back_valid),
    .res       (back_res),
    .res_ready (res_ready)
  );

  // output register and running rate sum
  assign res_ready      = !out_valid_r || !out_stall;
  assign load           = back_valid && res_ready;
  assign out_valid_nxt  = load || (out_valid_r && out_stall);
  assign sum_raw        = {1'b0, rate_total_r} + {{(SUM_WIDTH+1-VALUE_WIDTH){1'b0}},
                          back_res.local_rate};
  assign sum_sat        = sum_raw[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_raw[SUM_WIDTH-1:0];
  assign rate_total_nxt = !load ? rate_total_r : (back_res.last_out ? '0 : sum_sat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      rate_total_r <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      rate_total_r <= rate_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= back_res;
      sum_r <= sum_sat;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_index_out      = res_r.index_out;
  assign out_component_out  = res_r.component_out;
  assign out_new_param      = res_r.new_param;
  assign out_new_grad_accum = res_r.new_grad_accum;
  assign out_new_momentum   = res_r.new_momentum;
  assign out_local_rate     = res_r.local_rate;
  assign out_rate_sum       = sum_r;
  assign out_last_out       = res_r.last_out;

  // checks
  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    load && back_res.last_out |=> rate_total_r == '0)
    else $error("rate sum not cleared after last beat");

  a_sum_covers_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_rate_sum >= {16'b0, out_local_rate})
    else $error("rate sum below local rate");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ===== rtl/core/agu_front.sv =====
// front end: takes an item, forms the weighted gradient and queues it
module agu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  agu_pkg::item_t       in_item,
  input  logic signed [31:0]   sparse_wt,
  input  logic signed [31:0]   grad_in,
  input  logic                 mode,
  input  logic                 q_full,
  output logic                 push,
  output agu_pkg::qent_t       push_ent
);
  import agu_pkg::*;

  logic               s1_valid_r, s1_valid_nxt;
  item_t              item_r;
  logic               mode_r;
  logic signed [63:0] prod_r, prod_nxt;
  logic               accept;
  logic               wg_ovf;
  logic signed [31:0] wg;

  // hand-off control
  assign in_stall     = s1_valid_r && q_full;
  assign accept       = in_valid && !in_stall;
  assign push         = s1_valid_r && !q_full;
  assign s1_valid_nxt = accept ? 1'b1 : (push ? 1'b0 : s1_valid_r);
  assign prod_nxt     = sparse_wt * grad_in;

  // weighted gradient, floor shift and saturation
  assign wg_ovf = !((&prod_r[63:47]) || !(|prod_r[63:47]));
  assign wg     = wg_ovf ? (prod_r[63] ? SMIN : SMAX) : prod_r[47:16];

  assign push_ent.item = item_r;
  assign push_ent.mode = mode_r;
  assign push_ent.wg   = wg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // item register
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
      mode_r <= mode;
      prod_r <= prod_nxt;
    end
  end

endmodule

// ===== rtl/core/agu_queue.sv =====
// short queue between front and back end
module agu_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  agu_pkg::qent_t push_ent,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output agu_pkg::qent_t head
);
  import agu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qent_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = slots[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_ent;
    end
  end

endmodule

// ===== rtl/core/agu_rootdiv.sv =====
// shared iterative unit: square root or divide, one result bit per cycle
module agu_rootdiv (
  input  logic             clk,
  input  logic             rst_n,
  input  agu_pkg::rd_req_t req,
  output agu_pkg::rd_rsp_t rsp
);
  import agu_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  rd_op_t      op_r;
  logic [4:0]  cnt_r;
  logic [33:0] rem_r;
  logic [63:0] x_r;
  logic [31:0] root_r;
  logic [31:0] den_r;
  logic [31:0] res_r;

  logic [35:0] sq_cand, sq_trial, sq_diff;
  logic        sq_ge;
  logic [33:0] sq_rem_nxt;
  logic [31:0] root_nxt;
  logic [32:0] dv_cand, dv_diff;
  logic        dv_ge;
  logic [31:0] dv_rem_nxt;
  logic [63:0] dv_x_nxt;
  logic        div_sat;
  logic        last_step;

  // square root step
  assign sq_cand    = {rem_r, x_r[63:62]};
  assign sq_trial   = {2'b00, root_r, 2'b01};
  assign sq_ge      = (sq_cand >= sq_trial);
  assign sq_diff    = sq_cand - sq_trial;
  assign sq_rem_nxt = sq_ge ? sq_diff[33:0] : sq_cand[33:0];
  assign root_nxt   = {root_r[30:0], sq_ge};

  // divide step
  assign dv_cand    = {rem_r[31:0], x_r[63]};
  assign dv_ge      = (dv_cand >= {1'b0, den_r});
  assign dv_diff    = dv_cand - {1'b0, den_r};
  assign dv_rem_nxt = dv_ge ? dv_diff[31:0] : dv_cand[31:0];
  assign dv_x_nxt   = {x_r[62:0], dv_ge};

  // quotient would not fit in 32 bits, or divisor zero
  assign div_sat   = ({16'b0, req.a[47:32]} >= req.b);
  assign last_step = busy_r && (cnt_r == '0);

  // control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      if (req.op == RD_DIV && div_sat) begin
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (last_step) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r   <= req.op;
      cnt_r  <= 5'd31;
      root_r <= '0;
      den_r  <= req.b;
      if (req.op == RD_DIV) begin
        rem_r <= {18'b0, req.a[47:32]};
        x_r   <= {req.a[31:0], 32'b0};
        if (div_sat) begin
          res_r <= UMAX;
        end
      end else begin
        rem_r <= '0;
        x_r   <= req.a;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (op_r == RD_SQRT) begin
        rem_r  <= sq_rem_nxt;
        root_r <= root_nxt;
        x_r    <= {x_r[61:0], 2'b00};
        if (last_step) begin
          res_r <= root_nxt;
        end
      end else begin
        rem_r <= {2'b00, dv_rem_nxt};
        x_r   <= dv_x_nxt;
        if (last_step) begin
          res_r <= dv_x_nxt[31:0];
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

// ===== rtl/core/agu_back.sv =====
// back end: sequencer over a shared multiplier and the root/divide unit
module agu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  agu_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  agu_pkg::qent_t q_head,
  output logic           q_pop,
  output logic           res_valid,
  output agu_pkg::res_t  res,
  input  logic           res_ready
);
  import agu_pkg::*;

  back_state_t        state_r, state_nxt;
  qent_t              ent_r;
  logic signed [67:0] prod_r;
  logic signed [33:0] mul_a, mul_b;
  logic [31:0]        sq_r, new_acc_r, new_mom_r, root_g_r, rate_r, usq_r;
  logic signed [48:0] update_r;
  logic [63:0]        t_r;
  logic               neg_r;
  logic [31:0]        mag_r;
  logic [48:0]        factor_r;
  logic signed [31:0] np_r;
  rd_req_t            rd_req;
  rd_rsp_t            rd_rsp;

  logic [16:0]        q17;
  logic [31:0]        sq_c;
  logic [32:0]        acc_sum;
  logic [48:0]        gx, mx;
  logic [48:0]        na_sum;
  logic [48:0]        uneg;
  logic [47:0]        umag;
  logic [31:0]        usq_c;
  logic signed [49:0] diff;
  logic               p1_ovf;
  logic [31:0]        p1_c, p1_neg;
  logic [63:0]        res_sum;
  logic [47:0]        res_mag;
  logic               res_big;
  logic [31:0]        res_neg;

  agu_rootdiv u_rootdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rd_req),
    .rsp   (rd_rsp)
  );

  // arithmetic around the multiplier
  assign q17     = 17'h10000 - {1'b0, cfg.decay_rho};
  assign sq_c    = (prod_r[67:48] != '0) ? UMAX : prod_r[47:16];
  assign acc_sum = {1'b0, ent_r.item.grad_accum} + {1'b0, sq_c};
  assign gx      = {1'b0, new_acc_r, 16'b0} + {17'b0, cfg.epsilon};
  assign mx      = {1'b0, ent_r.item.momentum_accum, 16'b0} + {17'b0, cfg.epsilon};
  assign na_sum  = t_r[48:0] + prod_r[48:0];
  assign uneg    = -update_r;
  assign umag    = update_r[48] ? uneg[47:0] : update_r[47:0];
  assign usq_c   = ((umag[47:32] != '0) || (prod_r[63:48] != '0)) ? UMAX : prod_r[47:16];
  assign diff    = 50'(ent_r.item.param_value) - 50'(update_r);
  assign p1_ovf  = !((&diff[49:31]) || !(|diff[49:31]));
  assign p1_c    = p1_ovf ? (diff[49] ? SMIN : SMAX) : diff[31:0];
  assign p1_neg  = -p1_c;
  assign res_sum = t_r + {32'b0, prod_r[47:16]};
  assign res_mag = res_sum[63:16];
  assign res_big = (res_mag[47:31] != '0);
  assign res_neg = -res_mag[31:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (q_valid) state_nxt = B_SQ;
      B_SQ:    state_nxt = B_SQW;
      B_SQW:   state_nxt = (ent_r.mode == MODE_ADADELTA) ? B_NA1 : B_ROOTA;
      B_NA1:   state_nxt = B_NA2;
      B_NA2:   state_nxt = B_GX;
      B_GX:    state_nxt = B_ROOTG;
      B_ROOTG: if (rd_rsp.done) state_nxt = B_ROOTM;
      B_ROOTM: if (rd_rsp.done) state_nxt = B_DIV;
      B_ROOTA: if (rd_rsp.done) state_nxt = B_DIV;
      B_DIV:   if (rd_rsp.done) state_nxt = B_UPD;
      B_UPD:   state_nxt = B_UPDW;
      B_UPDW:  state_nxt = (ent_r.mode == MODE_ADADELTA) ? B_MOM1 : B_PAR;
      B_MOM1:  state_nxt = B_MOM2;
      B_MOM2:  state_nxt = B_MOM3;
      B_MOM3:  state_nxt = B_MOM4;
      B_MOM4:  state_nxt = B_PAR;
      B_PAR:   state_nxt = B_FAC;
      B_FAC:   state_nxt = B_MH;
      B_MH:    state_nxt = B_ML;
      B_ML:    state_nxt = B_RES;
      B_RES:   state_nxt = B_OUT;
      B_OUT:   if (res_ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs: operand select, unit requests, handshakes
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    rd_req    = '0;
    q_pop     = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      B_IDLE: begin
        q_pop = q_valid;
      end
      B_SQ: begin
        mul_a = 34'(ent_r.wg);
        mul_b = 34'(ent_r.wg);
      end
      B_SQW: begin
        if (ent_r.mode == MODE_ADADELTA) begin
          mul_a = {18'b0, cfg.decay_rho};
          mul_b = {2'b0, ent_r.item.grad_accum};
        end else begin
          rd_req.start = 1'b1;
          rd_req.op    = RD_SQRT;
          rd_req.a     = {ent_r.item.grad_accum, 32'b0};
        end
      end
      B_NA1: begin
        mul_a = {17'b0, q17};
        mul_b = {2'b0, sq_r};
      end
      B_GX: begin
        rd_req.start = 1'b1;
        rd_req.op    = RD_SQRT;
        rd_req.a     = {1'b0, gx, 14'b0};
      end
      B_ROOTG: begin
        rd_req.start = rd_rsp.done;
        rd_req.op    = RD_SQRT;
        rd_req.a     = {1'b0, mx, 14'b0};
      end
      B_ROOTM: begin
        rd_req.start = rd_rsp.done;
        rd_req.op    = RD_DIV;
        rd_req.a     = {16'b0, rd_rsp.res, 16'b0};
        rd_req.b     = root_g_r;
      end
      B_ROOTA: begin
        rd_req.start = rd_rsp.done;
        rd_req.op    = RD_DIV;
        rd_req.a     = {24'b0, cfg.learn_rate, 24'b0};
        rd_req.b     = rd_rsp.res;
      end
      B_UPD: begin
        mul_a = {2'b0, rate_r};
        mul_b = 34'(ent_r.wg);
      end
      B_MOM1: begin
        mul_a = {2'b0, umag[31:0]};
        mul_b = {2'b0, umag[31:0]};
      end
      B_MOM2: begin
        mul_a = {18'b0, cfg.decay_rho};
        mul_b = {2'b0, ent_r.item.momentum_accum};
      end
      B_MOM3: begin
        mul_a = {17'b0, q17};
        mul_b = {2'b0, usq_r};
      end
      B_PAR: begin
        mul_a = {18'b0, cfg.reg_alpha};
        mul_b = {2'b0, rate_r};
      end
      B_MH: begin
        mul_a = {2'b0, mag_r};
        mul_b = {1'b0, factor_r[48:16]};
      end
      B_ML: begin
        mul_a = {2'b0, mag_r};
        mul_b = {18'b0, factor_r[15:0]};
      end
      B_OUT: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // shared multiplier with registered product
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          ent_r     <= q_head;
          new_mom_r <= q_head.item.momentum_accum;
        end
      end
      B_SQW: begin
        sq_r      <= sq_c;
        new_acc_r <= acc_sum[32] ? UMAX : acc_sum[31:0];
      end
      B_NA1: begin
        t_r <= prod_r[63:0];
      end
      B_NA2: begin
        new_acc_r <= na_sum[47:16];
      end
      B_ROOTG: begin
        if (rd_rsp.done) root_g_r <= rd_rsp.res;
      end
      B_DIV: begin
        if (rd_rsp.done) rate_r <= rd_rsp.res;
      end
      B_UPDW: begin
        update_r <= prod_r[64:16];
      end
      B_MOM2: begin
        usq_r <= usq_c;
      end
      B_MOM3: begin
        t_r <= prod_r[63:0];
      end
      B_MOM4: begin
        new_mom_r <= na_sum[47:16];
      end
      B_PAR: begin
        neg_r <= p1_c[31];
        mag_r <= p1_c[31] ? p1_neg : p1_c;
      end
      B_FAC: begin
        factor_r <= {1'b0, prod_r[47:0]} + 49'h1_0000_0000;
      end
      B_ML: begin
        t_r <= prod_r[63:0];
      end
      B_RES: begin
        if (neg_r) begin
          np_r <= res_big ? SMIN : res_neg;
        end else begin
          np_r <= res_big ? SMAX : res_mag[31:0];
        end
      end
      default: begin
        t_r <= t_r;
      end
    endcase
  end

  assign res.index_out      = ent_r.item.feature_index;
  assign res.component_out  = ent_r.item.component_index;
  assign res.new_param      = np_r;
  assign res.new_grad_accum = new_acc_r;
  assign res.new_momentum   = new_mom_r;
  assign res.local_rate     = rate_r;
  assign res.last_out       = ent_r.item.last;

endmodule
